// File: rtl/scc_pkg.sv
// Shared types and constants for the servo force-curve correction block.
// Used by the top level, the iterative divider and the port checker.
// No dependencies.
package scc_pkg;

  // Item kind carried on in_tuser
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CORRECT = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_NEUTRAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FORCE   = 3'd4;

  // Angles, unsigned Q9.8 degrees
  localparam int unsigned ANG_W = 17;
  localparam logic [ANG_W-1:0] ANG_LOW  = 17'd10240;
  localparam logic [ANG_W-1:0] ANG_MID  = 17'd23040;
  localparam logic [ANG_W-1:0] ANG_HIGH = 17'd35840;

  // Divider geometry
  localparam int unsigned DIV_REM_W = 33;
  localparam int unsigned DIV_Q_W   = 32;
  localparam int unsigned DIV_CNT_W = 6;

  typedef struct packed {
    logic                 start;
    logic [DIV_REM_W-1:0] rem_init;
    logic [DIV_Q_W-1:0]   q_init;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_REM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/servo_force_curve_correction.sv
// Servo force-curve correction: top level with sequencer, shared multiplier and curve RAM.
// Depends on scc_pkg, scc_ram and scc_div.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in_     | slave     | in_tvalid / in_tready  | in_tuser: operation; in_tdata: entry_index,
//          |           |                        |   entry_force, raw_pulse
//  out_    | master    | out_tvalid / out_tready| out_tdata: corrected_servo, chosen_angle
//  cfg_    | slave     | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// A load beat writes the curve RAM and finishes in its accept cycle; it gives no result.
// A correct beat runs through the sequencer; its length is set by the shared
// one-bit-per-cycle divider, which produces 32, 8 and 18 quotient bits, and by the
// binary search, one RAM read per probe. Saturating or out-of-curve cases skip a
// division and finish sooner.
// in_tready is high only while the sequencer idles. A finished result waits in the output
// register, so a stalled out_tready holds the sequencer only at its last step.
// Reset (rst_n low, synchronous) restores the configuration defaults; the curve RAM is not
// cleared and must be loaded before use.
module servo_force_curve_correction #(
  parameter int unsigned CURVE_SIZE = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,    // [0] operation
  input  logic [55:0] in_tdata,    // [6:0] entry_index, [38:7] entry_force,
                                   // [54:39] raw_pulse, [55] zero
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [15:0] corrected_servo, [31:16] chosen_angle
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IDX_W = $clog2(CURVE_SIZE);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CURVE_SIZE - 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_FMUL  = 14'b00000000000010,
    S_FDIV  = 14'b00000000000100,
    S_FWAIT = 14'b00000000001000,
    S_RD0   = 14'b00000000010000,
    S_CMP0  = 14'b00000000100000,
    S_CMPL  = 14'b00000001000000,
    S_PROBE = 14'b00000010000000,
    S_IDIV  = 14'b00000100000000,
    S_IWAIT = 14'b00001000000000,
    S_PMUL  = 14'b00010000000000,
    S_PDIV  = 14'b00100000000000,
    S_PWAIT = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  // Configuration registers
  logic [15:0] pwm_min_r, pwm_neutral_r, pwm_max_r;
  logic [13:0] max_angle_r;
  logic [30:0] max_force_r;

  // Sequencer and datapath registers
  state_t                   state_r, state_nxt;
  logic [15:0]              servo_r, servo_nxt;
  logic [47:0]              prod_r, prod_nxt;
  logic                     sign_r, sign_nxt;
  logic [15:0]              dsr_r, dsr_nxt;
  logic signed [31:0]       force_r, force_nxt;
  logic signed [31:0]       c_lo_r, c_lo_nxt;
  logic signed [31:0]       c_hi_r, c_hi_nxt;
  logic [IDX_W-1:0]         lo_r, lo_nxt;
  logic [IDX_W-1:0]         hi_r, hi_nxt;
  logic [scc_pkg::ANG_W-1:0] angle_r, angle_nxt;
  logic [15:0]              base_r, base_nxt;
  logic [15:0]              pulse_r, pulse_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [15:0]              out_servo_r, out_servo_nxt;
  logic [15:0]              out_angle_r, out_angle_nxt;

  // Input payload fields
  logic        in_accept;
  logic [6:0]  in_index;
  logic [31:0] in_force;
  logic [15:0] in_servo;

  assign in_index  = in_tdata[6:0];
  assign in_force  = in_tdata[38:7];
  assign in_servo  = in_tdata[54:39];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // Curve RAM
  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  assign ram_we = in_accept && (in_tuser == scc_pkg::OP_LOAD) &&
                  (32'(in_index) < CURVE_SIZE);

  scc_ram #(
    .WIDTH (32),
    .DEPTH (CURVE_SIZE)
  ) u_curve (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_index)),
    .wdata (in_force),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared divider
  scc_pkg::div_req_t div_req;
  scc_pkg::div_rsp_t div_rsp;

  scc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Linear force terms: delta = neutral - servo, side range picked by pulse side
  logic        min_side;
  logic        delta_neg, rng_neg;
  logic [15:0] delta_mag, rng_mag;

  assign min_side  = (servo_r < pwm_neutral_r) == (pwm_min_r < pwm_max_r);
  assign delta_neg = servo_r > pwm_neutral_r;
  assign delta_mag = delta_neg ? (servo_r - pwm_neutral_r) : (pwm_neutral_r - servo_r);

  always_comb begin
    if (min_side) begin
      rng_neg = pwm_min_r > pwm_neutral_r;
      rng_mag = rng_neg ? (pwm_min_r - pwm_neutral_r) : (pwm_neutral_r - pwm_min_r);
    end else begin
      rng_neg = pwm_neutral_r > pwm_max_r;
      rng_mag = rng_neg ? (pwm_neutral_r - pwm_max_r) : (pwm_max_r - pwm_neutral_r);
    end
  end

  // Reverse angle map terms: each side scales by its own pulse range
  logic               above_mid;
  logic signed [17:0] ang_term;
  logic [16:0]        ang_mag;
  logic               ang_neg;
  logic               dd_neg;
  logic [15:0]        dd_mag;

  assign above_mid = angle_r > scc_pkg::ANG_MID;
  assign ang_term  = above_mid ?
      $signed(18'(scc_pkg::ANG_MID) + 18'(max_angle_r) - 18'(angle_r)) :
      $signed(18'(scc_pkg::ANG_MID) - 18'(angle_r));
  assign ang_neg   = ang_term[17];
  assign ang_mag   = ang_neg ? 17'(-ang_term) : ang_term[16:0];

  always_comb begin
    if (above_mid) begin
      dd_neg = pwm_min_r > pwm_neutral_r;
      dd_mag = dd_neg ? (pwm_min_r - pwm_neutral_r) : (pwm_neutral_r - pwm_min_r);
    end else begin
      dd_neg = pwm_neutral_r > pwm_max_r;
      dd_mag = dd_neg ? (pwm_neutral_r - pwm_max_r) : (pwm_max_r - pwm_neutral_r);
    end
  end

  // Shared multiplier, registered into prod_r
  logic [16:0] mul_a;
  logic [30:0] mul_b;
  logic [47:0] mul_p;

  assign mul_a = (state_r == S_FMUL) ? {1'b0, delta_mag} : ang_mag;
  assign mul_b = (state_r == S_FMUL) ? max_force_r : {15'b0, dd_mag};
  assign mul_p = mul_a * mul_b;

  // Binary search probe
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic             probe_gt;
  logic [IDX_W-1:0] lo_probe, hi_probe;
  logic [IDX_W:0]   probe_sum;
  logic             probe_more;

  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid        = mid_sum[IDX_W:1];
  assign probe_gt   = $signed(ram_rdata) > force_r;
  assign lo_probe   = probe_gt ? lo_r : mid;
  assign hi_probe   = probe_gt ? mid : hi_r;
  assign probe_sum  = {1'b0, lo_probe} + {1'b0, hi_probe};
  assign probe_more = {1'b0, hi_probe} > ({1'b0, lo_probe} + 1'b1);

  always_comb begin
    unique case (state_r)
      S_CMP0:  ram_raddr = LAST;
      S_CMPL:  ram_raddr = mid;
      S_PROBE: ram_raddr = probe_sum[IDX_W:1];
      default: ram_raddr = '0;
    endcase
  end

  // Interpolation operands: both stay non-negative by the search invariant
  logic [32:0] lo_gap, hi_gap;

  assign lo_gap = {force_r[31], force_r} - {c_lo_r[31], c_lo_r};
  assign hi_gap = {c_hi_r[31], c_hi_r} - {c_lo_r[31], c_lo_r};

  // Pulse from divider quotient, saturated to 0..65535
  logic [17:0] pq;
  logic [19:0] psum;

  assign pq   = div_rsp.quot[17:0];
  assign psum = sign_r ? (20'(base_r) - 20'(pq)) : (20'(base_r) + 20'(pq));

  // Force from divider quotient, saturated to the signed 32-bit range
  logic [31:0] fq;
  logic [31:0] fq_sat;

  assign fq = div_rsp.quot;
  always_comb begin
    if (sign_r) begin
      fq_sat = fq[31] ? 32'h8000_0000 : 32'(-fq);
    end else begin
      fq_sat = fq[31] ? 32'h7FFF_FFFF : fq;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    servo_nxt      = servo_r;
    prod_nxt       = prod_r;
    sign_nxt       = sign_r;
    dsr_nxt        = dsr_r;
    force_nxt      = force_r;
    c_lo_nxt       = c_lo_r;
    c_hi_nxt       = c_hi_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    angle_nxt      = angle_r;
    base_nxt       = base_r;
    pulse_nxt      = pulse_r;
    out_servo_nxt  = out_servo_r;
    out_angle_nxt  = out_angle_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    div_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        // Loads finish here through the RAM write port
        if (in_accept && (in_tuser == scc_pkg::OP_CORRECT)) begin
          servo_nxt = in_servo;
          state_nxt = S_FMUL;
        end
      end
      S_FMUL: begin
        prod_nxt = mul_p;
        sign_nxt = delta_neg ^ rng_neg;
        dsr_nxt  = rng_mag;
        if (rng_mag == '0) begin
          force_nxt = '0;
          state_nxt = S_RD0;
        end else begin
          state_nxt = S_FDIV;
        end
      end
      S_FDIV: begin
        if (prod_r[47:32] >= dsr_r) begin
          // Quotient reaches 2^32: saturate without dividing
          force_nxt = sign_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          state_nxt = S_RD0;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = 33'(prod_r[47:32]);
          div_req.q_init   = prod_r[31:0];
          div_req.steps    = 6'd32;
          div_req.divisor  = 33'(dsr_r);
          state_nxt        = S_FWAIT;
        end
      end
      S_FWAIT: begin
        if (div_rsp.done) begin
          force_nxt = fq_sat;
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        state_nxt = S_CMP0;
      end
      S_CMP0: begin
        c_lo_nxt = ram_rdata;
        lo_nxt   = '0;
        hi_nxt   = LAST;
        if (force_r < $signed(ram_rdata)) begin
          angle_nxt = scc_pkg::ANG_LOW;
          state_nxt = S_PMUL;
        end else begin
          state_nxt = S_CMPL;
        end
      end
      S_CMPL: begin
        c_hi_nxt = ram_rdata;
        if (force_r >= $signed(ram_rdata)) begin
          angle_nxt = scc_pkg::ANG_HIGH;
          state_nxt = S_PMUL;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        lo_nxt = lo_probe;
        hi_nxt = hi_probe;
        if (probe_gt) begin
          c_hi_nxt = ram_rdata;
        end else begin
          c_lo_nxt = ram_rdata;
        end
        if (!probe_more) begin
          state_nxt = S_IDIV;
        end
      end
      S_IDIV: begin
        // (force - lo) * 256 / (hi - lo), known to be below 256
        div_req.start    = 1'b1;
        div_req.rem_init = lo_gap;
        div_req.q_init   = '0;
        div_req.steps    = 6'd8;
        div_req.divisor  = hi_gap;
        state_nxt        = S_IWAIT;
      end
      S_IWAIT: begin
        if (div_rsp.done) begin
          angle_nxt = scc_pkg::ANG_LOW + scc_pkg::ANG_W'({lo_r, div_rsp.quot[7:0]});
          state_nxt = S_PMUL;
        end
      end
      S_PMUL: begin
        if (max_angle_r == '0) begin
          pulse_nxt = pwm_neutral_r;
          state_nxt = S_OUT;
        end else begin
          prod_nxt  = mul_p;
          sign_nxt  = ang_neg ^ dd_neg;
          dsr_nxt   = 16'(max_angle_r);
          base_nxt  = above_mid ? pwm_min_r : pwm_neutral_r;
          state_nxt = S_PDIV;
        end
      end
      S_PDIV: begin
        if (prod_r[47:18] >= 30'(dsr_r)) begin
          // Quotient reaches 2^18: the pulse leaves 0..65535 either way
          pulse_nxt = sign_r ? 16'h0000 : 16'hFFFF;
          state_nxt = S_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = 33'(prod_r[47:18]);
          div_req.q_init   = {prod_r[17:0], 14'b0};
          div_req.steps    = 6'd18;
          div_req.divisor  = 33'(dsr_r);
          state_nxt        = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (div_rsp.done) begin
          if (psum[19]) begin
            pulse_nxt = 16'h0000;
          end else if (psum[18:16] != '0) begin
            pulse_nxt = 16'hFFFF;
          end else begin
            pulse_nxt = psum[15:0];
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_servo_nxt  = pulse_r;
          out_angle_nxt  = angle_r[15:0];
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_tvalid_r  <= 1'b0;
      pwm_min_r     <= 16'd1000;
      pwm_neutral_r <= 16'd1500;
      pwm_max_r     <= 16'd2000;
      max_angle_r   <= 14'd10240;
      max_force_r   <= 31'd65536;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          scc_pkg::REG_PWM_MIN:     pwm_min_r     <= cfg_data[15:0];
          scc_pkg::REG_PWM_NEUTRAL: pwm_neutral_r <= cfg_data[15:0];
          scc_pkg::REG_PWM_MAX:     pwm_max_r     <= cfg_data[15:0];
          scc_pkg::REG_MAX_ANGLE:   max_angle_r   <= cfg_data[13:0];
          scc_pkg::REG_MAX_FORCE:   max_force_r   <= cfg_data[30:0];
          default: begin
            // drop writes beyond the register list
          end
        endcase
      end
    end
    servo_r     <= servo_nxt;
    prod_r      <= prod_nxt;
    sign_r      <= sign_nxt;
    dsr_r       <= dsr_nxt;
    force_r     <= force_nxt;
    c_lo_r      <= c_lo_nxt;
    c_hi_r      <= c_hi_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    angle_r     <= angle_nxt;
    base_r      <= base_nxt;
    pulse_r     <= pulse_nxt;
    out_servo_r <= out_servo_nxt;
    out_angle_r <= out_angle_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_angle_r, out_servo_r};

endmodule

// File: rtl/scc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/scc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on scc_pkg for the request and response structs.
module scc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  scc_pkg::div_req_t req,
  output scc_pkg::div_rsp_t rsp
);

  logic [scc_pkg::DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [scc_pkg::DIV_Q_W-1:0]   q_r, q_nxt;
  logic [scc_pkg::DIV_REM_W-1:0] dsr_r, dsr_nxt;
  logic [scc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic [scc_pkg::DIV_REM_W:0]   shifted;
  logic [scc_pkg::DIV_REM_W:0]   diff;
  logic                          fits;

  // Shift in the next dividend bit and try the subtract
  assign shifted = {rem_r, q_r[scc_pkg::DIV_Q_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign fits    = shifted >= {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      rem_nxt  = req.rem_init;
      q_nxt    = req.q_init;
      dsr_nxt  = req.divisor;
      cnt_nxt  = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_nxt = fits ? diff[scc_pkg::DIV_REM_W-1:0] : shifted[scc_pkg::DIV_REM_W-1:0];
        q_nxt   = {q_r[scc_pkg::DIV_Q_W-2:0], fits};
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = busy_r && (cnt_r == '0);
  assign rsp.quot = q_r;

endmodule

// File: rtl/scc_checker.sv
// Port-level checker for the servo force-curve correction block, bound to the top level.
// Depends on scc_pkg for the item kind codes.
module scc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic in_tuser,
  input logic out_tvalid,
  input logic out_tready
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // A correct beat occupies the sequencer
  a_busy_after_correct: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == scc_pkg::OP_CORRECT) |=> !in_tready)
    else $error("input ready right after a correct beat");

  // A load beat never yields a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == scc_pkg::OP_LOAD) && !out_tvalid
    |=> !out_tvalid)
    else $error("result appeared after a load beat");

  // A result appears only at the end of a busy sequence
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while the sequencer was idle");

endmodule

bind servo_force_curve_correction scc_checker u_scc_checker (.*);
